@@ hdl/fref_pkg.sv @@
// Shared types and constants for the flight reference block.
package fref_pkg;

  typedef enum logic [3:0] {
    FN_TAKEOFF  = 4'd0,
    FN_HOVER    = 4'd1,
    FN_LAND     = 4'd2,
    FN_HEIGHT   = 4'd3,
    FN_FWD      = 4'd4,
    FN_BACK     = 4'd5,
    FN_LEFT     = 4'd6,
    FN_RIGHT    = 4'd7,
    FN_CW       = 4'd8,
    FN_CCW      = 4'd9,
    FN_WAIT     = 4'd10,
    FN_FOLLOW   = 4'd11,
    FN_ACTION   = 4'd12,
    FN_HOME     = 4'd13,
    FN_LAND_NOW = 4'd14,
    FN_INVALID  = 4'd15
  } func_e;

  localparam logic [7:0] ACTION_CODE_MAX = 8'd5;

  localparam logic [2:0] REG_DEADBAND       = 3'd0;
  localparam logic [2:0] REG_GAIN           = 3'd1;
  localparam logic [2:0] REG_CLIMB_MAX      = 3'd2;
  localparam logic [2:0] REG_DESCENT_NORMAL = 3'd3;
  localparam logic [2:0] REG_DESCENT_LAND   = 3'd4;
  localparam logic [2:0] REG_SLEW_NORMAL    = 3'd5;
  localparam logic [2:0] REG_SLEW_LAND_NOW  = 3'd6;

  localparam logic [30:0] RST_DEADBAND       = 31'd3277;
  localparam logic [23:0] RST_GAIN           = 24'd65536;
  localparam logic [30:0] RST_CLIMB_MAX      = 31'd65536;
  localparam logic [31:0] RST_DESCENT_NORMAL = 32'hFFFF_8000;
  localparam logic [31:0] RST_DESCENT_LAND   = 32'hFFFF_B333;
  localparam logic [30:0] RST_SLEW_NORMAL    = 31'd655;
  localparam logic [30:0] RST_SLEW_LAND_NOW  = 31'd1311;

  // Reciprocal of 100 for a 32-bit dividend: q = (x * CM_RECIP) >> 37.
  localparam logic [30:0] CM_RECIP = 31'd1374389535;
  localparam logic [31:0] CM_ROUND = 32'd50;
  // Pi over 180 in Q0.32.
  localparam logic [26:0] DEG_SCALE = 27'd74961321;
  localparam logic [42:0] DEG_ROUND = 43'd32768;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic        [30:0] deadband;
    logic        [23:0] gain;
    logic        [30:0] climb_max;
    logic signed [31:0] descent_normal;
    logic signed [31:0] descent_land;
    logic        [30:0] slew_normal;
    logic        [30:0] slew_land_now;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] yaw_rate;
    logic signed [31:0] z_now;
    logic        [15:0] timeout;
    logic               err;
    logic               land;
    logic               fast_land;
  } ref_word_t;

endpackage

@@ hdl/flight_reference_with_altitude_loop.sv @@
// Top level of the flight reference generator with the vertical outer loop.
//
//   channel  handshake                  payload
//   input    in_valid_i / in_ready_o    func_i .. y_now_i
//   output   out_valid_o / out_ready_i  out_px_o .. error_o
//   config   psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// One word is accepted per cycle unless the queue is full.
// The vertical speed register is updated once per word, which allows that rate.
// A four-entry queue lets the front end keep accepting while the output is stalled.
// Reset restores all register defaults and clears the reference state; no clearing pass.
module flight_reference_with_altitude_loop import fref_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         func_i,
  input  logic [15:0]        height_or_distance_cm_i,
  input  logic [15:0]        speed_value_i,
  input  logic [15:0]        hold_time_s_i,
  input  logic [7:0]         action_code_i,
  input  logic signed [31:0] altitude_now_i,
  input  logic signed [31:0] x_now_i,
  input  logic signed [31:0] y_now_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_px_o,
  output logic signed [31:0] out_py_o,
  output logic signed [31:0] out_pz_o,
  output logic signed [31:0] out_vx_o,
  output logic signed [31:0] out_vy_o,
  output logic signed [31:0] out_vz_o,
  output logic signed [31:0] out_yaw_rate_o,
  output logic signed [31:0] vz_target_o,
  output logic [15:0]        timeout_sec_o,
  output logic               error_o
);

  cfg_t      cfg;
  ref_word_t push_word, head_word, out_word;
  logic      push, full, pop, empty;

  fref_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fref_front u_front (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_ready_o              (in_ready_o),
    .func_i                  (func_i),
    .height_or_distance_cm_i (height_or_distance_cm_i),
    .speed_value_i           (speed_value_i),
    .hold_time_s_i           (hold_time_s_i),
    .action_code_i           (action_code_i),
    .altitude_now_i          (altitude_now_i),
    .x_now_i                 (x_now_i),
    .y_now_i                 (y_now_i),
    .full_i                  (full),
    .push_o                  (push),
    .word_o                  (push_word)
  );

  fref_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (push_word),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .word_o  (head_word)
  );

  fref_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .empty_i     (empty),
    .word_i      (head_word),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word),
    .out_vz_o    (out_vz_o),
    .vz_target_o (vz_target_o)
  );

  assign out_px_o       = out_word.px;
  assign out_py_o       = out_word.py;
  assign out_pz_o       = out_word.pz;
  assign out_vx_o       = out_word.vx;
  assign out_vy_o       = out_word.vy;
  assign out_yaw_rate_o = out_word.yaw_rate;
  assign timeout_sec_o  = out_word.timeout;
  assign error_o        = out_word.err;

endmodule

@@ hdl/fref_cfg.sv @@
// Configuration register file behind the APB-style port.
module fref_cfg import fref_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t        cfg_q;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband       <= RST_DEADBAND;
      cfg_q.gain           <= RST_GAIN;
      cfg_q.climb_max      <= RST_CLIMB_MAX;
      cfg_q.descent_normal <= RST_DESCENT_NORMAL;
      cfg_q.descent_land   <= RST_DESCENT_LAND;
      cfg_q.slew_normal    <= RST_SLEW_NORMAL;
      cfg_q.slew_land_now  <= RST_SLEW_LAND_NOW;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEADBAND:       cfg_q.deadband       <= pwdata[30:0];
        REG_GAIN:           cfg_q.gain           <= pwdata[23:0];
        REG_CLIMB_MAX:      cfg_q.climb_max      <= pwdata[30:0];
        REG_DESCENT_NORMAL: cfg_q.descent_normal <= pwdata;
        REG_DESCENT_LAND:   cfg_q.descent_land   <= pwdata;
        REG_SLEW_NORMAL:    cfg_q.slew_normal    <= pwdata[30:0];
        REG_SLEW_LAND_NOW:  cfg_q.slew_land_now  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEADBAND:       prdata = {1'b0, cfg_q.deadband};
      REG_GAIN:           prdata = {8'd0, cfg_q.gain};
      REG_CLIMB_MAX:      prdata = {1'b0, cfg_q.climb_max};
      REG_DESCENT_NORMAL: prdata = cfg_q.descent_normal;
      REG_DESCENT_LAND:   prdata = cfg_q.descent_land;
      REG_SLEW_NORMAL:    prdata = {1'b0, cfg_q.slew_normal};
      REG_SLEW_LAND_NOW:  prdata = {1'b0, cfg_q.slew_land_now};
      default:            prdata = '0;
    endcase
  end

endmodule

@@ hdl/fref_front.sv @@
// Front end: accepts commands, converts units and updates the horizontal and altitude reference.
module fref_front import fref_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         func_i,
  input  logic [15:0]        height_or_distance_cm_i,
  input  logic [15:0]        speed_value_i,
  input  logic [15:0]        hold_time_s_i,
  input  logic [7:0]         action_code_i,
  input  logic signed [31:0] altitude_now_i,
  input  logic signed [31:0] x_now_i,
  input  logic signed [31:0] y_now_i,
  input  logic               full_i,
  output logic               push_o,
  output ref_word_t          word_o
);

  logic               s1_valid_q;
  func_e              func_q;
  logic [15:0]        hold_q;
  logic [7:0]         act_q;
  logic signed [31:0] z_q, xn_q, yn_q;
  logic [25:0]        dist_q, spd_q;
  logic [26:0]        deg_q;

  logic [31:0]        dist_num, spd_num;
  logic [62:0]        dist_prod, spd_prod;
  logic [42:0]        deg_prod;
  logic               accept;

  logic signed [31:0] x_pos_q, y_pos_q, x_vel_q, y_vel_q, yaw_ref_q, alt_q;
  logic signed [31:0] x_pos_d, y_pos_d, x_vel_d, y_vel_d, yaw_ref_d, alt_d;
  logic [15:0]        timeout_q, timeout_d;
  logic               err, land, fast_land;
  logic signed [31:0] dist32, spd32, deg32;

  assign dist_num  = {height_or_distance_cm_i, 16'd0} + CM_ROUND;
  assign spd_num   = {speed_value_i, 16'd0} + CM_ROUND;
  assign dist_prod = 63'(dist_num) * 63'(CM_RECIP);
  assign spd_prod  = 63'(spd_num) * 63'(CM_RECIP);
  assign deg_prod  = 43'(speed_value_i) * 43'(DEG_SCALE) + DEG_ROUND;

  assign push_o     = s1_valid_q && !full_i;
  assign in_ready_o = !s1_valid_q || push_o;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(func_i);
      hold_q <= hold_time_s_i;
      act_q  <= action_code_i;
      z_q    <= altitude_now_i;
      xn_q   <= x_now_i;
      yn_q   <= y_now_i;
      dist_q <= dist_prod[62:37];
      spd_q  <= spd_prod[62:37];
      deg_q  <= deg_prod[42:16];
    end
  end

  assign dist32 = $signed({6'd0, dist_q});
  assign spd32  = $signed({6'd0, spd_q});
  assign deg32  = $signed({5'd0, deg_q});

  always_comb begin
    x_pos_d   = x_pos_q;
    y_pos_d   = y_pos_q;
    x_vel_d   = x_vel_q;
    y_vel_d   = y_vel_q;
    yaw_ref_d = yaw_ref_q;
    alt_d     = alt_q;
    timeout_d = timeout_q;
    err       = 1'b0;
    land      = 1'b0;
    fast_land = 1'b0;
    if (!(func_q == FN_WAIT || func_q == FN_FOLLOW || func_q == FN_ACTION ||
          func_q == FN_INVALID)) begin
      x_pos_d   = '0;
      y_pos_d   = '0;
      x_vel_d   = '0;
      y_vel_d   = '0;
      yaw_ref_d = '0;
      timeout_d = '0;
    end
    unique case (func_q) inside
      FN_TAKEOFF, FN_HEIGHT, FN_HOME: alt_d = dist32;
      FN_HOVER: begin
        alt_d     = dist32;
        timeout_d = hold_q;
      end
      FN_LAND: begin
        alt_d = '0;
        land  = 1'b1;
      end
      FN_FWD: begin
        x_pos_d = dist32;
        x_vel_d = spd32;
      end
      FN_BACK: begin
        x_pos_d = -dist32;
        x_vel_d = -spd32;
      end
      FN_LEFT: begin
        y_pos_d = -dist32;
        y_vel_d = -spd32;
      end
      FN_RIGHT: begin
        y_pos_d = dist32;
        y_vel_d = spd32;
      end
      FN_CW:     yaw_ref_d = -deg32;
      FN_CCW:    yaw_ref_d = deg32;
      FN_WAIT:   timeout_d = hold_q;
      FN_FOLLOW: timeout_d = '0;
      FN_ACTION: err = act_q > ACTION_CODE_MAX;
      FN_LAND_NOW: begin
        x_pos_d   = xn_q;
        y_pos_d   = yn_q;
        alt_d     = '0;
        land      = 1'b1;
        fast_land = 1'b1;
      end
      FN_INVALID: err = 1'b1;
      default: err = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_pos_q   <= '0;
      y_pos_q   <= '0;
      x_vel_q   <= '0;
      y_vel_q   <= '0;
      yaw_ref_q <= '0;
      alt_q     <= '0;
      timeout_q <= '0;
    end else if (push_o) begin
      x_pos_q   <= x_pos_d;
      y_pos_q   <= y_pos_d;
      x_vel_q   <= x_vel_d;
      y_vel_q   <= y_vel_d;
      yaw_ref_q <= yaw_ref_d;
      alt_q     <= alt_d;
      timeout_q <= timeout_d;
    end
  end

  assign word_o.px        = x_pos_d;
  assign word_o.py        = y_pos_d;
  assign word_o.pz        = alt_d;
  assign word_o.vx        = x_vel_d;
  assign word_o.vy        = y_vel_d;
  assign word_o.yaw_rate  = yaw_ref_d;
  assign word_o.z_now     = z_q;
  assign word_o.timeout   = timeout_d;
  assign word_o.err       = err;
  assign word_o.land      = land;
  assign word_o.fast_land = fast_land;

endmodule

@@ hdl/fref_fifo.sv @@
// Short queue of reference words between the front end and the vertical loop.
module fref_fifo import fref_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ref_word_t word_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output ref_word_t word_o
);

  ref_word_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   count_q;
  logic                  do_push, do_pop;

  assign full_o  = count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign word_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

@@ hdl/fref_back.sv @@
// Vertical outer loop: deadband, gain, clamp and slew limit, with the output register.
module fref_back import fref_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               empty_i,
  input  ref_word_t          word_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ref_word_t          out_word_o,
  output logic signed [31:0] out_vz_o,
  output logic signed [31:0] vz_target_o
);

  logic               en;
  logic               a_valid_q, b_valid_q, c_valid_q, o_valid_q;
  ref_word_t          a_word_q, b_word_q, c_word_q, o_word_q;
  logic signed [32:0] a_zerr_q, a_zerr_d, db_pos;
  logic               a_db_q, a_db_d, b_db_q;
  logic [40:0]        b_plo_q, b_plo_d;
  logic signed [40:0] b_phi_q, b_phi_d;
  logic signed [57:0] c_sum;
  logic signed [41:0] c_raw, c_hi, c_lo, c_clip;
  logic signed [31:0] c_vmin;
  logic signed [31:0] c_target_q, c_target_d;
  logic signed [32:0] d_delta, d_lim, d_step;
  logic signed [31:0] vz_q, vz_d, o_vz_q, o_target_q;

  assign en    = !o_valid_q || out_ready_i;
  assign pop_o = en && !empty_i;

  assign db_pos   = $signed({2'b00, cfg_i.deadband});
  assign a_zerr_d = $signed({word_i.pz[31], word_i.pz}) -
                    $signed({word_i.z_now[31], word_i.z_now});
  assign a_db_d   = (a_zerr_d < db_pos) && (a_zerr_d > -db_pos);

  assign b_plo_d = 41'(cfg_i.gain) * 41'(a_zerr_q[16:0]);
  assign b_phi_d = $signed({1'b0, cfg_i.gain}) * $signed(a_zerr_q[32:17]);

  always_comb begin
    c_sum  = ($signed({{17{b_phi_q[40]}}, b_phi_q}) <<< 17) +
             $signed({17'd0, b_plo_q}) + 58'sd32768;
    c_raw  = b_db_q ? '0 : c_sum[57:16];
    c_vmin = b_word_q.land ? cfg_i.descent_land : cfg_i.descent_normal;
    c_hi   = $signed({11'd0, cfg_i.climb_max});
    c_lo   = $signed({{10{c_vmin[31]}}, c_vmin});
    c_clip = (c_raw > c_hi) ? c_hi : c_raw;
    if (c_clip < c_lo) begin
      c_clip = c_lo;
    end
    c_target_d = b_word_q.err ? '0 : c_clip[31:0];
  end

  always_comb begin
    d_step  = $signed({2'b00, c_word_q.fast_land ? cfg_i.slew_land_now : cfg_i.slew_normal});
    d_delta = $signed({c_target_q[31], c_target_q}) - $signed({vz_q[31], vz_q});
    d_lim   = d_delta;
    if (d_delta > d_step) begin
      d_lim = d_step;
    end else if (d_delta < -d_step) begin
      d_lim = -d_step;
    end
    vz_d = c_word_q.err ? vz_q : vz_q + d_lim[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      vz_q      <= '0;
    end else if (en) begin
      a_valid_q <= !empty_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      o_valid_q <= c_valid_q;
      if (c_valid_q) begin
        vz_q <= vz_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_word_q   <= word_i;
      a_zerr_q   <= a_zerr_d;
      a_db_q     <= a_db_d;
      b_word_q   <= a_word_q;
      b_plo_q    <= b_plo_d;
      b_phi_q    <= b_phi_d;
      b_db_q     <= a_db_q;
      c_word_q   <= b_word_q;
      c_target_q <= c_target_d;
      o_word_q   <= c_word_q;
      o_vz_q     <= vz_d;
      o_target_q <= c_target_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_word_o  = o_word_q;
  assign out_vz_o    = o_vz_q;
  assign vz_target_o = o_target_q;

endmodule
